/* sv/eud_pkg.sv */
// ----------------------------------------------------------------------------
// eud_pkg
// Shared types and constants for the edge unit direction and normal block.
// ----------------------------------------------------------------------------
package eud_pkg;

	// Latency of one vector normaliser, in pipeline advances.
	localparam int unsigned U3_LAT = 53;

	// One in Q2.14.
	localparam logic [14:0] Q14_ONE = 15'd16384;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_COMP_THR = 1'b0,
		CFG_LEN_THR  = 1'b1
	} cfg_idx_t;

	// A 3-vector as sign and magnitude; magnitudes reach 2^32 - 1.
	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][32:0] mag;
	} vec_sm_t;

	// Side data travelling alongside the normal normaliser.
	typedef struct packed {
		logic [2:0][15:0] dir;
		logic             zl;
		logic             fixed;
	} side_t;

endpackage

/* sv/eud_unit3.sv */
// ----------------------------------------------------------------------------
// eud_unit3
// Pipelined 3-vector normaliser: block scaling, sum of squares, bit-per-stage
// square root and bit-per-stage division, giving Q2.14 components.
// ----------------------------------------------------------------------------
module eud_unit3 (
	input  logic                clk,
	input  logic                en,
	input  eud_pkg::vec_sm_t    vin,
	output logic [2:0][15:0]    res,
	output logic                zero
);
	import eud_pkg::*;

	// Stage A: magnitudes and their maximum.
	logic [2:0][32:0] m_a;
	logic [2:0]       neg_a;
	logic [32:0]      mx_a;
	logic [32:0]      mx01;

	always_comb begin
		mx01 = (vin.mag[0] > vin.mag[1]) ? vin.mag[0] : vin.mag[1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_a   <= vin.mag;
			neg_a <= vin.neg;
			mx_a  <= (mx01 > vin.mag[2]) ? mx01 : vin.mag[2];
		end
	end

	// Stage B: position of the leading one of the maximum.
	logic [2:0][32:0] m_b;
	logic [2:0]       neg_b;
	logic [5:0]       pos_b;
	logic             zero_b;
	logic [5:0]       pos_c;

	always_comb begin
		pos_c = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (mx_a[i]) begin
				pos_c = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_b    <= m_a;
			neg_b  <= neg_a;
			pos_b  <= pos_c;
			zero_b <= (mx_a == 33'd0);
		end
	end

	// Stage C: shift all magnitudes so the largest lies in [2^23, 2^24).
	logic [2:0][23:0] mn_c;
	logic [2:0]       neg_cq;
	logic             zero_c;
	logic [2:0][32:0] sh;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_b >= 6'd23) begin
				sh[i] = m_b[i] >> (pos_b - 6'd23);
			end else begin
				sh[i] = m_b[i] << (6'd23 - pos_b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mn_c[i] <= sh[i][23:0];
			end
			neg_cq <= neg_b;
			zero_c <= zero_b;
		end
	end

	// Stage D: squares.
	logic [2:0][47:0] sqr_d;
	logic [2:0][23:0] mn_d;
	logic [2:0]       neg_d;
	logic             zero_d;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqr_d[i] <= mn_c[i] * mn_c[i];
			end
			mn_d   <= mn_c;
			neg_d  <= neg_cq;
			zero_d <= zero_c;
		end
	end

	// Square root pipeline; index 0 is the sum of squares stage.
	logic [34:0]      sq_r    [0:31];
	logic [30:0]      sq_q    [0:31];
	logic [49:0]      sq_s    [0:31];
	logic [2:0][23:0] sq_m    [0:31];
	logic [2:0]       sq_neg  [0:31];
	logic             sq_zero [0:31];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_r[0]    <= 35'd0;
			sq_q[0]    <= 31'd0;
			sq_s[0]    <= 50'(sqr_d[0]) + 50'(sqr_d[1]) + 50'(sqr_d[2]);
			sq_m[0]    <= mn_d;
			sq_neg[0]  <= neg_d;
			sq_zero[0] <= zero_d;
		end
	end

	for (genvar k = 0; k < 31; k++) begin : g_sqrt
		logic [61:0] x;
		logic [34:0] rt;
		logic [34:0] tt;

		// Bring down two radicand bits and try the next root bit.
		always_comb begin
			x  = {sq_s[k], 12'd0};
			rt = {sq_r[k][32:0], x[61-2*k -: 2]};
			tt = {2'b00, sq_q[k], 2'b01};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rt >= tt) begin
					sq_r[k+1] <= rt - tt;
					sq_q[k+1] <= {sq_q[k][29:0], 1'b1};
				end else begin
					sq_r[k+1] <= rt;
					sq_q[k+1] <= {sq_q[k][29:0], 1'b0};
				end
				sq_s[k+1]    <= sq_s[k];
				sq_m[k+1]    <= sq_m[k];
				sq_neg[k+1]  <= sq_neg[k];
				sq_zero[k+1] <= sq_zero[k];
			end
		end
	end

	// Division pipeline; index 0 holds the rounded dividends.
	logic [2:0][45:0] dv_r    [0:15];
	logic [2:0][14:0] dv_q    [0:15];
	logic [30:0]      dv_len  [0:15];
	logic [2:0]       dv_neg  [0:15];
	logic             dv_zero [0:15];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_r[0][i] <= {2'b00, sq_m[31][i], 20'd0} + 46'(sq_q[31][30:1]);
				dv_q[0][i] <= 15'd0;
			end
			dv_len[0]  <= sq_q[31];
			dv_neg[0]  <= sq_neg[31];
			dv_zero[0] <= sq_zero[31];
		end
	end

	for (genvar j = 0; j < 15; j++) begin : g_div
		logic [45:0] dsh;

		always_comb begin
			dsh = {15'd0, dv_len[j]} << (14 - j);
		end

		// One quotient bit per stage, restoring.
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_r[j][i] >= dsh) begin
						dv_r[j+1][i] <= dv_r[j][i] - dsh;
						dv_q[j+1][i] <= dv_q[j][i] | (15'd1 << (14 - j));
					end else begin
						dv_r[j+1][i] <= dv_r[j][i];
						dv_q[j+1][i] <= dv_q[j][i];
					end
				end
				dv_len[j+1]  <= dv_len[j];
				dv_neg[j+1]  <= dv_neg[j];
				dv_zero[j+1] <= dv_zero[j];
			end
		end
	end

	// Stage G: clamp to one, apply the sign, force zero for a null vector.
	logic [2:0][15:0] qs;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_q[15][i] > Q14_ONE) begin
				qs[i] = {1'b0, Q14_ONE};
			end else begin
				qs[i] = {1'b0, dv_q[15][i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero[15]) begin
					res[i] <= 16'd0;
				end else if (dv_neg[15][i]) begin
					res[i] <= 16'd0 - qs[i];
				end else begin
					res[i] <= qs[i];
				end
			end
			zero <= dv_zero[15];
		end
	end

endmodule

/* sv/edge_unit_direction_and_normal.sv */
// ----------------------------------------------------------------------------
// edge_unit_direction_and_normal
// Unit direction and unit normal of an edge from its two endpoints.
// ----------------------------------------------------------------------------
// The block takes one edge per clock cycle while the pipeline is not held,
// and returns one result item per edge, in order. Most of the pipeline is
// two normalisers in series, each 53 stages long, mostly a one-bit-per-stage
// square root and a one-bit-per-stage divider. When the output item is not
// taken the whole pipeline holds and in_ready falls in the same cycle.
// Configuration writes must be made while no item is in flight.
module edge_unit_direction_and_normal (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] last_x,
	input  logic signed [31:0] last_y,
	input  logic signed [31:0] last_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic               zero_length,
	output logic               zero_normal,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import eud_pkg::*;

	logic        en;
	logic [14:0] ct_q;
	logic [31:0] lt_q;

	// The pipeline advances unless a finished item waits at the output.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_q <= 15'd1;
			lt_q <= 32'd4295;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COMP_THR: ct_q <= cfg_data[14:0];
				CFG_LEN_THR:  lt_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Stage 1: difference vector in sign and magnitude form.
	logic signed [2:0][32:0] dd;
	vec_sm_t                 d_s1;
	logic                    v_s1;

	always_comb begin
		dd[0] = 33'(last_x) - 33'(first_x);
		dd[1] = 33'(last_y) - 33'(first_y);
		dd[2] = 33'(last_z) - 33'(first_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1.neg[i] <= dd[i][32];
				d_s1.mag[i] <= dd[i][32] ? 33'd0 - dd[i] : dd[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	// Zero-length test: squares of short components, then the compare.
	logic [2:0][31:0] zsq_s2;
	logic             zsmall_s2;
	logic             zl_s3;
	logic [33:0]      zsum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				zsq_s2[i] <= d_s1.mag[i][15:0] * d_s1.mag[i][15:0];
			end
			zsmall_s2 <= (d_s1.mag[0] < 33'd65536) && (d_s1.mag[1] < 33'd65536) &&
				(d_s1.mag[2] < 33'd65536);
		end
	end

	assign zsum = 34'(zsq_s2[0]) + 34'(zsq_s2[1]) + 34'(zsq_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			zl_s3 <= zsmall_s2 && (zsum < {2'b00, lt_q});
		end
	end

	// Direction normaliser with the difference vector kept alongside.
	logic [2:0][15:0] u_res;
	logic             u_zero;
	vec_sm_t          d_line  [0:U3_LAT-1];
	logic             zl_line [0:U3_LAT-3];
	logic             v_line1 [0:U3_LAT-1];

	eud_unit3 u_dir (
		.clk  (clk),
		.en   (en),
		.vin  (d_s1),
		.res  (u_res),
		.zero (u_zero)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d_line[0]  <= d_s1;
			zl_line[0] <= zl_s3;
			for (int k = 1; k < U3_LAT; k++) begin
				d_line[k] <= d_line[k-1];
			end
			for (int k = 1; k < U3_LAT - 2; k++) begin
				zl_line[k] <= zl_line[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < U3_LAT; k++) begin
				v_line1[k] <= 1'b0;
			end
		end else if (en) begin
			v_line1[0] <= v_s1;
			for (int k = 1; k < U3_LAT; k++) begin
				v_line1[k] <= v_line1[k-1];
			end
		end
	end

	// Branch stage: pick the perpendicular from the direction.
	vec_sm_t          dq;
	logic [2:0][14:0] um;
	logic [2:0]       sm;
	vec_sm_t          w_c;
	logic             fixed_c;
	vec_sm_t          w_sb;
	side_t            side_sb;
	logic             v_sb;

	always_comb begin
		dq = d_line[U3_LAT-1];
		for (int i = 0; i < 3; i++) begin
			um[i] = u_res[i][15] ? 15'(16'd0 - u_res[i]) : u_res[i][14:0];
			sm[i] = um[i] < ct_q;
		end
		w_c     = '0;
		fixed_c = 1'b0;
		if (sm[2]) begin
			if (sm[0]) begin
				fixed_c = 1'b1;
			end else begin
				w_c.neg[0] = dq.neg[0] ? dq.neg[1] : !dq.neg[1];
				w_c.mag[0] = dq.mag[1];
				w_c.mag[1] = dq.mag[0];
			end
		end else if (sm[1]) begin
			if (sm[0]) begin
				fixed_c = 1'b1;
			end else begin
				w_c.neg[0] = dq.neg[0] ? dq.neg[2] : !dq.neg[2];
				w_c.mag[0] = dq.mag[2];
				w_c.mag[2] = dq.mag[0];
			end
		end else begin
			w_c.mag[0] = dq.mag[1];
			w_c.neg[1] = dq.neg[1] ? dq.neg[0] : !dq.neg[0];
			w_c.mag[1] = dq.mag[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_sb          <= w_c;
			side_sb.dir   <= u_res;
			side_sb.zl    <= zl_line[U3_LAT-3];
			side_sb.fixed <= fixed_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sb <= 1'b0;
		end else if (en) begin
			v_sb <= v_line1[U3_LAT-1];
		end
	end

	// Normal normaliser with the side data kept alongside.
	logic [2:0][15:0] n_res;
	logic             n_zero;
	side_t            side_line [0:U3_LAT-1];
	logic             v_line2   [0:U3_LAT-1];

	eud_unit3 u_norm (
		.clk  (clk),
		.en   (en),
		.vin  (w_sb),
		.res  (n_res),
		.zero (n_zero)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_line[0] <= side_sb;
			for (int k = 1; k < U3_LAT; k++) begin
				side_line[k] <= side_line[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < U3_LAT; k++) begin
				v_line2[k] <= 1'b0;
			end
		end else if (en) begin
			v_line2[0] <= v_sb;
			for (int k = 1; k < U3_LAT; k++) begin
				v_line2[k] <= v_line2[k-1];
			end
		end
	end

	// Output register.
	side_t sd;

	assign sd = side_line[U3_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dir_x       <= sd.dir[0];
			dir_y       <= sd.dir[1];
			dir_z       <= sd.dir[2];
			zero_length <= sd.zl;
			if (sd.fixed) begin
				norm_x      <= {1'b0, Q14_ONE};
				norm_y      <= 16'sd0;
				norm_z      <= 16'sd0;
				zero_normal <= 1'b0;
			end else begin
				norm_x      <= n_res[0];
				norm_y      <= n_res[1];
				norm_z      <= n_res[2];
				zero_normal <= n_zero;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_line2[U3_LAT-1];
		end
	end

endmodule

/* sv/eud_checker.sv */
// ----------------------------------------------------------------------------
// eud_checker
// Port-level checks on the edge unit direction and normal block.
// ----------------------------------------------------------------------------
module eud_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] dir_x,
	input logic signed [15:0] norm_x,
	input logic signed [15:0] norm_y,
	input logic signed [15:0] norm_z,
	input logic               zero_normal
);

	// A waiting result item stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item withdrawn while stalled");

	// A stalled output holds the whole pipeline, input included.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// A zero normal flag comes with an all-zero normal.
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_normal |-> norm_x == 16'sd0 && norm_y == 16'sd0 &&
			norm_z == 16'sd0)
		else $error("zero normal with non-zero components");

	// The x direction component never exceeds one in magnitude.
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384)
		else $error("direction component out of range");

endmodule

bind edge_unit_direction_and_normal eud_checker u_eud_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.dir_x       (dir_x),
	.norm_x      (norm_x),
	.norm_y      (norm_y),
	.norm_z      (norm_z),
	.zero_normal (zero_normal)
);
